// ----- rtl/core/wnd_pkg.sv -----
// Shared types and constants for the window nearest-difference core.
// Used by the channel interfaces and the core; depends on nothing.
`default_nettype none

package wnd_pkg;

	localparam int STORE_ROWS_DEF  = 8;
	localparam int STORE_WIDTH_DEF = 4096;

	localparam int ROW_W = 16;
	localparam int COL_W = 12;
	localparam int PIX_W = 16;
	localparam int CFG_W = 16;
	localparam int IDX_W = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_WINDOW_SIZE   = 3'd0,
		REG_HALF_PIXEL    = 3'd1,
		REG_OUTPUT_MODE   = 3'd2,
		REG_IMAGE_LINES   = 3'd3,
		REG_IMAGE_SAMPLES = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_SIGNED    = 2'd0,
		MODE_MAGNITUDE = 2'd1,
		MODE_OFFSET    = 2'd2
	} out_mode_t;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_TARGET = 1'b1
	} opcode_t;

	localparam logic [2:0]  WINDOW_RST  = 3'd3;
	localparam logic [15:0] LINES_RST   = 16'd1;
	localparam logic [12:0] SAMPLES_RST = 13'd1;

	// seeds of the search when nothing is visited
	localparam logic signed [16:0] MIN_INIT = 17'sd123;
	localparam logic [19:0]        MAG_INIT = 20'd999999;
	localparam logic [15:0]        OUT_OFFSET = 16'd128;

endpackage

`default_nettype wire

// ----- rtl/core/wnd_item_if.sv -----
// Input channel: valid/ready handshake with load or target payload.
// Depends on wnd_pkg for field widths.
`default_nettype none

interface wnd_item_if;
	logic                             valid;
	logic                             ready;
	logic                             opcode;
	logic [wnd_pkg::ROW_W-1:0]        row;
	logic [wnd_pkg::COL_W-1:0]        col;
	logic signed [wnd_pkg::PIX_W-1:0] pixel;

	modport source (output valid, opcode, row, col, pixel, input ready);
	modport sink (input valid, opcode, row, col, pixel, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/wnd_result_if.sv -----
// Result channel: valid/ready handshake with difference and status.
// Depends on wnd_pkg for field widths.
`default_nettype none

interface wnd_result_if;
	logic                             valid;
	logic                             ready;
	logic signed [wnd_pkg::PIX_W-1:0] difference;
	logic                             bad_setting;

	modport source (output valid, difference, bad_setting, input ready);
	modport sink (input valid, difference, bad_setting, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/wnd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wnd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/window_nearest_difference_core.sv -----
// Window nearest-difference core: ring of reference rows, window search per target.
// Load: accept, reciprocal row-to-slot, RAM write; no result. Target: accept,
// row-to-slot, centre read, rewind, per position a read and compare (and half-pixel
// compare; none outside), set by the single RAM read port and shared compare unit.
// Bad-setting target: accept, finish. One item at a time; result register frees the
// output side. Reset: control and registers to defaults; the reference store is not
// cleared. Depends on wnd_pkg, wnd_item_if, wnd_result_if, wnd_ram.
`default_nettype none

module window_nearest_difference_core #(
	parameter int STORE_ROWS  = wnd_pkg::STORE_ROWS_DEF,
	parameter int STORE_WIDTH = wnd_pkg::STORE_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	wnd_item_if.sink                        item,
	wnd_result_if.source                    result,
	input  wire logic                       cfg_wr_en,
	input  wire logic [wnd_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [wnd_pkg::CFG_W-1:0]  cfg_data
);

	localparam int DEPTH  = STORE_ROWS * STORE_WIDTH;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SLOT_W = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;

	// ceil(2^20 / STORE_ROWS): exact quotient for every 16-bit row
	localparam int          RECIP_SH = 20;
	localparam logic [20:0] RECIP    =
		21'(((64'd1 << RECIP_SH) + 64'(STORE_ROWS) - 64'd1) / 64'(STORE_ROWS));

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MOD,
		ST_SLOT,
		ST_LOAD_WR,
		ST_CTR_RD,
		ST_CTR_WAIT,
		ST_REWIND,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SCAN_HALF,
		ST_FINISH
	} state_t;

	// configuration
	logic [2:0]  wsize_q;
	logic        half_q;
	logic [1:0]  mode_q;
	logic [15:0] lines_q;
	logic [12:0] samples_q;

	// sequencer and datapath registers
	state_t             state_q;
	logic               opcode_q;
	logic [15:0]        row_q;
	logic [11:0]        col_q;
	logic signed [15:0] pix_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [15:0]        quot_q;
	logic signed [15:0] centre_q;
	logic signed [17:0] r_q;
	logic signed [13:0] c_q;
	logic [1:0]         rew_q;
	logic signed [16:0] best_min_q;
	logic [19:0]        best_mag_q;
	logic               bad_q;
	logic               out_valid_q;
	logic [15:0]        out_diff_q;
	logic               out_bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsize_q   <= wnd_pkg::WINDOW_RST;
			half_q    <= 1'b0;
			mode_q    <= wnd_pkg::MODE_SIGNED;
			lines_q   <= wnd_pkg::LINES_RST;
			samples_q <= wnd_pkg::SAMPLES_RST;
		end else if (cfg_wr_en) begin
			unique case (wnd_pkg::reg_idx_t'(cfg_index))
				wnd_pkg::REG_WINDOW_SIZE:   wsize_q   <= cfg_data[2:0];
				wnd_pkg::REG_HALF_PIXEL:    half_q    <= cfg_data[0];
				wnd_pkg::REG_OUTPUT_MODE:   mode_q    <= cfg_data[1:0];
				wnd_pkg::REG_IMAGE_LINES:   lines_q   <= cfg_data;
				wnd_pkg::REG_IMAGE_SAMPLES: samples_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	logic [1:0] half;
	logic       bad_cfg;
	assign half    = wsize_q[2:1];
	assign bad_cfg = !wsize_q[0] || (half_q && (wsize_q > 3'd3));

	// row-to-slot: quotient by reciprocal multiply, then remainder next cycle
	logic [35:0] quot_full;
	logic [15:0] slot_base;
	logic [15:0] slot_rem;
	always_comb begin
		quot_full = 36'(row_q) * 36'(RECIP);
		slot_base = quot_q * 16'(STORE_ROWS);
		slot_rem  = row_q - slot_base;
	end

	logic [SLOT_W-1:0] slot_inc;
	logic [SLOT_W-1:0] slot_dec;
	assign slot_inc = (slot_q == SLOT_W'(STORE_ROWS - 1)) ? '0 : slot_q + 1'b1;
	assign slot_dec = (slot_q == '0) ? SLOT_W'(STORE_ROWS - 1) : slot_q - 1'b1;

	// window walk
	logic signed [17:0] r_start, r_end;
	logic signed [13:0] c_start, c_end;
	logic               last_c, last_r, scan_done;
	logic               row_ok, col_ok, pos_ok, ctr_ok, load_ok;
	always_comb begin
		r_start   = $signed({2'b00, row_q}) - $signed({16'b0, half});
		r_end     = $signed({2'b00, row_q}) + $signed({16'b0, half});
		c_start   = $signed({2'b00, col_q}) - $signed({12'b0, half});
		c_end     = $signed({2'b00, col_q}) + $signed({12'b0, half});
		last_c    = (c_q == c_end);
		last_r    = (r_q == r_end);
		scan_done = last_c && last_r;
		row_ok    = !r_q[17] && (r_q < $signed({2'b00, lines_q}));
		col_ok    = !c_q[13] && (c_q[12:0] < samples_q) && (32'(c_q[12:0]) < STORE_WIDTH);
		pos_ok    = row_ok && col_ok;
		ctr_ok    = 32'(col_q) < STORE_WIDTH;
		load_ok   = ctr_ok;
	end

	// store access
	logic [13:0]      addr_col;
	logic [AW-1:0]    ram_addr;
	logic             ram_wr, ram_rd;
	logic [15:0]      ram_rdata;
	always_comb begin
		addr_col = (state_q == ST_SCAN_RD) ? c_q[13:0] : {2'b00, col_q};
		ram_addr = AW'(slot_q) * AW'(STORE_WIDTH) + AW'(addr_col);
		ram_wr   = (state_q == ST_LOAD_WR) && load_ok;
		ram_rd   = ((state_q == ST_CTR_RD) && ctr_ok) || ((state_q == ST_SCAN_RD) && pos_ok);
	end

	wnd_ram #(
		.WIDTH (wnd_pkg::PIX_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (ram_addr),
		.wr_data (pix_q),
		.rd_en   (ram_rd),
		.rd_addr (ram_addr),
		.rd_data (ram_rdata)
	);

	// shared candidate / compare unit: plain difference, then half-pixel average
	logic signed [16:0] avg_sum, avg_adj, avg, sub, cand;
	logic [16:0]        mag;
	logic               better;
	always_comb begin
		avg_sum = $signed({ram_rdata[15], ram_rdata}) + $signed({centre_q[15], centre_q});
		avg_adj = avg_sum + $signed({16'b0, avg_sum[16]});
		avg     = avg_adj >>> 1;
		sub     = (state_q == ST_SCAN_HALF) ? avg : $signed({ram_rdata[15], ram_rdata});
		cand    = $signed({pix_q[15], pix_q}) - sub;
		mag     = cand[16] ? 17'(-cand) : 17'(cand);
		better  = {3'b000, mag} < best_mag_q;
	end

	logic [15:0] res_val;
	always_comb begin
		case (wnd_pkg::out_mode_t'(mode_q))
			wnd_pkg::MODE_MAGNITUDE: res_val = best_mag_q[15:0];
			wnd_pkg::MODE_OFFSET:    res_val = best_min_q[15:0] + wnd_pkg::OUT_OFFSET;
			default:                 res_val = best_min_q[15:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			opcode_q    <= wnd_pkg::OP_LOAD;
			row_q       <= '0;
			col_q       <= '0;
			pix_q       <= '0;
			slot_q      <= '0;
			quot_q      <= '0;
			centre_q    <= '0;
			r_q         <= '0;
			c_q         <= '0;
			rew_q       <= '0;
			best_min_q  <= wnd_pkg::MIN_INIT;
			best_mag_q  <= wnd_pkg::MAG_INIT;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_diff_q  <= '0;
			out_bad_q   <= 1'b0;
		end else begin
			// ST_FINISH owns the valid flag in its own cycle
			if (out_valid_q && result.ready && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						opcode_q   <= item.opcode;
						row_q      <= item.row;
						col_q      <= item.col;
						pix_q      <= item.pixel;
						slot_q     <= '0;
						best_min_q <= wnd_pkg::MIN_INIT;
						best_mag_q <= wnd_pkg::MAG_INIT;
						if ((item.opcode == wnd_pkg::OP_TARGET) && bad_cfg) begin
							bad_q   <= 1'b1;
							state_q <= ST_FINISH;
						end else begin
							bad_q   <= 1'b0;
							state_q <= ST_MOD;
						end
					end
				end
				ST_MOD: begin
					quot_q  <= quot_full[35:20];
					state_q <= ST_SLOT;
				end
				ST_SLOT: begin
					slot_q  <= slot_rem[SLOT_W-1:0];
					state_q <= (opcode_q == wnd_pkg::OP_LOAD) ? ST_LOAD_WR : ST_CTR_RD;
				end
				ST_LOAD_WR: begin
					state_q <= ST_IDLE;
				end
				ST_CTR_RD: begin
					state_q <= ST_CTR_WAIT;
				end
				ST_CTR_WAIT: begin
					centre_q <= ctr_ok ? $signed(ram_rdata) : '0;
					r_q      <= r_start;
					c_q      <= c_start;
					rew_q    <= half;
					state_q  <= (half == 2'd0) ? ST_SCAN_RD : ST_REWIND;
				end
				ST_REWIND: begin
					// walk the ring slot back to the top row of the window
					slot_q <= slot_dec;
					rew_q  <= rew_q - 1'b1;
					if (rew_q == 2'd1) begin
						state_q <= ST_SCAN_RD;
					end
				end
				ST_SCAN_RD, ST_SCAN_CMP, ST_SCAN_HALF: begin
					if ((state_q != ST_SCAN_RD) && better) begin
						best_mag_q <= {3'b000, mag};
						best_min_q <= cand;
					end
					if ((state_q == ST_SCAN_RD) && pos_ok) begin
						state_q <= ST_SCAN_CMP;
					end else if ((state_q == ST_SCAN_CMP) && half_q) begin
						state_q <= ST_SCAN_HALF;
					end else if (scan_done) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_SCAN_RD;
						if (last_c) begin
							r_q    <= r_q + 18'sd1;
							slot_q <= slot_inc;
							c_q    <= c_start;
						end else begin
							c_q <= c_q + 14'sd1;
						end
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						out_diff_q  <= bad_q ? 16'd0 : res_val;
						out_bad_q   <= bad_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign item.ready         = (state_q == ST_IDLE);
	assign result.valid       = out_valid_q;
	assign result.difference  = $signed(out_diff_q);
	assign result.bad_setting = out_bad_q;

endmodule

`default_nettype wire

// ----- tb/tb_window_nearest_difference_core.sv -----
// Self-checking testbench for window_nearest_difference_core: random and directed
// load/target traffic with a behavioral nearest-difference predictor and scoreboard.
// Depends on wnd_pkg, wnd_item_if, wnd_result_if and the core RTL.
`default_nettype none

module tb_window_nearest_difference_core;

	localparam int RING_ROWS   = wnd_pkg::STORE_ROWS_DEF;
	localparam int RING_WIDTH  = wnd_pkg::STORE_WIDTH_DEF;
	localparam int TAIL_CYCLES = 200;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 5000;

	typedef struct {
		wnd_pkg::opcode_t                 op;
		logic [wnd_pkg::ROW_W-1:0]        row;
		logic [wnd_pkg::COL_W-1:0]        col;
		logic signed [wnd_pkg::PIX_W-1:0] pixel;
	} sample_item_t;

	typedef struct {
		logic signed [wnd_pkg::PIX_W-1:0] difference;
		logic                             bad_setting;
	} diff_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_wr_en;
	logic [wnd_pkg::IDX_W-1:0] cfg_index;
	logic [wnd_pkg::CFG_W-1:0] cfg_data;

	wnd_item_if   items();
	wnd_result_if results();

	window_nearest_difference_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (items),
		.result    (results),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// settings as the core holds them
	logic [2:0]  cur_window  = wnd_pkg::WINDOW_RST;
	logic        cur_half    = 1'b0;
	logic [1:0]  cur_mode    = wnd_pkg::MODE_SIGNED;
	logic [15:0] cur_lines   = wnd_pkg::LINES_RST;
	logic [12:0] cur_samples = wnd_pkg::SAMPLES_RST;

	logic signed [wnd_pkg::PIX_W-1:0] ring_samples [RING_ROWS][RING_WIDTH];
	bit                               ring_written [RING_ROWS][RING_WIDTH];

	sample_item_t backlog[$];
	diff_result_t expected_diffs[$];
	int n_offered = 0;
	int n_taken = 0;
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int quiet = 0;

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] MISMATCH %s", $time, msg);
	endtask

	function automatic int ring_value(input int r, input int c);
		if (c >= RING_WIDTH)
			return 0;
		return ring_samples[r % RING_ROWS][c];
	endfunction

	function automatic void weigh(input int cand, inout int best, inout int best_mag);
		int mag;
		mag = (cand < 0) ? -cand : cand;
		if (mag < best_mag) begin
			best_mag = mag;
			best = cand;
		end
	endfunction

	function automatic diff_result_t nearest_difference(input logic [wnd_pkg::ROW_W-1:0] row,
			input logic [wnd_pkg::COL_W-1:0] col,
			input logic signed [wnd_pkg::PIX_W-1:0] pix);
		diff_result_t res;
		int span, lines, lim_c, rc, cc, best, best_mag, centre, nb, p, r, c, v;
		res.bad_setting = (cur_window[0] == 1'b0) || (cur_half && cur_window > 3'd3);
		res.difference = '0;
		if (res.bad_setting)
			return res;
		span = cur_window / 2;
		lines = cur_lines;
		lim_c = (cur_samples > RING_WIDTH) ? RING_WIDTH : cur_samples;
		rc = row;
		cc = col;
		p = pix;
		best = wnd_pkg::MIN_INIT;
		best_mag = wnd_pkg::MAG_INIT;
		centre = ring_value(rc, cc);
		for (r = rc - span; r <= rc + span; r++) begin
			if (r < 0 || r >= lines)
				continue;
			for (c = cc - span; c <= cc + span; c++) begin
				if (c < 0 || c >= lim_c)
					continue;
				nb = ring_value(r, c);
				weigh(p - nb, best, best_mag);
				// averaged candidate comes right after the plain one; SV division truncates
				if (cur_half)
					weigh(p - (nb + centre) / 2, best, best_mag);
			end
		end
		case (cur_mode)
			wnd_pkg::MODE_OFFSET:    v = best + int'(wnd_pkg::OUT_OFFSET);
			wnd_pkg::MODE_MAGNITUDE: v = best_mag;
			default:                 v = best;
		endcase
		res.difference = v[wnd_pkg::PIX_W-1:0];
		return res;
	endfunction

	function automatic logic signed [wnd_pkg::PIX_W-1:0] pick_sample();
		int v;
		case ($urandom_range(3))
			0: v = $urandom;
			1: begin
				case ($urandom_range(3))
					0: v = -32768;
					1: v = 32767;
					2: v = 0;
					default: v = -1;
				endcase
			end
			default: v = int'($urandom_range(40)) - 20;   // narrow spread gives ties
		endcase
		return v[wnd_pkg::PIX_W-1:0];
	endfunction

	function automatic int pick_coord(input int extent, input int top);
		int v;
		v = $urandom_range(extent + 1);
		return (v > top) ? top : v;
	endfunction

	function automatic void queue_item(input wnd_pkg::opcode_t op, input int r, input int c,
			input logic signed [wnd_pkg::PIX_W-1:0] v);
		sample_item_t it;
		it.op = op;
		it.row = r;
		it.col = c;
		it.pixel = v;
		backlog.push_back(it);
		n_offered++;
	endfunction

	function automatic void load_sample(input int r, input int c,
			input logic signed [wnd_pkg::PIX_W-1:0] v);
		ring_written[r % RING_ROWS][c] = 1'b1;
		queue_item(wnd_pkg::OP_LOAD, r, c, v);
	endfunction

	function automatic void need_sample(input int r, input int c);
		if (c < RING_WIDTH && !ring_written[r % RING_ROWS][c])
			load_sample(r, c, pick_sample());
	endfunction

	// Loads every slot the window (and centre) will touch that holds nothing yet.
	function automatic void plan_target(input int row, input int col,
			input logic signed [wnd_pkg::PIX_W-1:0] pix);
		int span, lim_c, r, c;
		span = cur_window / 2;
		lim_c = (cur_samples > RING_WIDTH) ? RING_WIDTH : cur_samples;
		need_sample(row, col);
		for (r = row - span; r <= row + span; r++) begin
			if (r < 0 || r >= cur_lines)
				continue;
			for (c = col - span; c <= col + span; c++) begin
				if (c >= 0 && c < lim_c)
					need_sample(r, c);
			end
		end
		queue_item(wnd_pkg::OP_TARGET, row, col, pix);
	endfunction

	function automatic void random_traffic(input int n_targets);
		repeat (n_targets) begin
			if ($urandom_range(2) == 0)
				load_sample(pick_coord(cur_lines, 65534), pick_coord(cur_samples, RING_WIDTH - 1),
					pick_sample());
			if ($urandom_range(19) == 0)
				load_sample($urandom_range(65534), $urandom_range(RING_WIDTH - 1), pick_sample());
			plan_target(pick_coord(cur_lines, 65534), pick_coord(cur_samples, RING_WIDTH - 1),
				pick_sample());
		end
	endfunction

	task automatic write_reg(input wnd_pkg::reg_idx_t idx,
			input logic [wnd_pkg::CFG_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
	endtask

	task automatic configure(input int w, input int h, input int m, input int l, input int s);
		write_reg(wnd_pkg::REG_WINDOW_SIZE, w);
		write_reg(wnd_pkg::REG_HALF_PIXEL, h);
		write_reg(wnd_pkg::REG_OUTPUT_MODE, m);
		write_reg(wnd_pkg::REG_IMAGE_LINES, l);
		write_reg(wnd_pkg::REG_IMAGE_SAMPLES, s);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_window = w;
		cur_half = h;
		cur_mode = m;
		cur_lines = l;
		cur_samples = s;
	endtask

	task automatic pace(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// Wait until every queued item is taken and every result is back, then let
	// a trailing load finish before anything touches the registers.
	task automatic settle();
		do
			@(posedge clk);
		while (n_taken != n_offered || expected_diffs.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin : feed
		sample_item_t nxt;
		if (!arst_n) begin
			items.valid <= 1'b0;
		end else begin
			if (items.valid && items.ready) begin
				if (items.opcode == wnd_pkg::OP_LOAD) begin
					if (items.col < RING_WIDTH)
						ring_samples[items.row % RING_ROWS][items.col] = items.pixel;
				end else begin
					expected_diffs.push_back(nearest_difference(items.row, items.col, items.pixel));
				end
				n_taken++;
			end
			if (!items.valid || items.ready) begin
				if (backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = backlog.pop_front();
					items.valid <= 1'b1;
					items.opcode <= nxt.op;
					items.row <= nxt.row;
					items.col <= nxt.col;
					items.pixel <= nxt.pixel;
				end else begin
					items.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : drain
		diff_result_t want;
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else begin
			if (results.valid && results.ready) begin
				if (expected_diffs.size() == 0) begin
					report_mismatch($sformatf("unexpected result difference=%0d bad_setting=%0b",
						results.difference, results.bad_setting));
				end else begin
					want = expected_diffs.pop_front();
					if (results.difference !== want.difference ||
							results.bad_setting !== want.bad_setting)
						report_mismatch($sformatf("difference=%0d/%0d bad_setting=%0b/%0b (got/exp)",
							results.difference, want.difference, results.bad_setting,
							want.bad_setting));
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				results.ready <= 1'b0;
			end else if (hold_ack != hold_req) begin
				hold_left <= HOLD_CYCLES;
				hold_ack <= hold_req;
				results.ready <= 1'b0;
			end else begin
				results.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((items.valid && items.ready) || (results.valid && results.ready)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("watchdog: no transaction in %0d cycles", QUIET_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin : stimulus
		int bad_win[4];
		int bad_half[4];
		int k;
		bad_win = '{0, 4, 5, 7};
		bad_half = '{0, 0, 1, 1};
		items.valid = 1'b0;
		items.opcode = wnd_pkg::OP_LOAD;
		items.row = '0;
		items.col = '0;
		items.pixel = '0;
		results.ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = wnd_pkg::REG_WINDOW_SIZE;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: full-scale wrap, then nothing inside the image
		pace(26, 26);
		load_sample(0, 0, -32768);
		plan_target(0, 0, 32767);
		plan_target(0, 0, -32768);
		plan_target(5, 0, 100);
		plan_target(0, RING_WIDTH - 1, 7);
		settle();

		configure(1, 0, wnd_pkg::MODE_MAGNITUDE, 1, 1);
		plan_target(5, 0, 1);
		plan_target(0, 0, -32768);
		settle();
		configure(1, 0, wnd_pkg::MODE_OFFSET, 1, 1);
		plan_target(5, 0, 1);
		plan_target(0, 0, 32767);
		settle();
		configure(1, 0, 3, 1, 1);
		plan_target(0, 0, 5);
		settle();

		for (k = 0; k < 4; k++) begin
			configure(bad_win[k], bad_half[k], wnd_pkg::MODE_SIGNED, 4, 4);
			plan_target(1, 1, pick_sample());
			settle();
		end

		// odd neighbour+centre sum checks truncation toward zero
		configure(3, 1, wnd_pkg::MODE_SIGNED, 4, 4);
		load_sample(1, 1, -3);
		load_sample(0, 1, 0);
		load_sample(1, 0, 2);
		plan_target(1, 1, 0);
		plan_target(0, 0, 32767);
		plan_target(3, 3, -32768);
		settle();

		configure(3, 0, wnd_pkg::MODE_SIGNED, 65535, RING_WIDTH);
		plan_target(65534, RING_WIDTH - 1, 32767);
		plan_target(0, 0, -32768);
		settle();

		configure(3, 1, wnd_pkg::MODE_SIGNED, 6, 10);
		pace(0, 0);
		random_traffic(80);
		settle();

		configure(5, 0, wnd_pkg::MODE_MAGNITUDE, 20, 12);
		pace(82, 0);
		random_traffic(80);
		settle();

		configure(7, 0, wnd_pkg::MODE_OFFSET, 9, 9);
		pace(0, 82);
		random_traffic(80);
		settle();

		configure(1, 1, 3, 65535, RING_WIDTH);
		pace(26, 26);
		random_traffic(80);
		settle();

		// sink stalls for a long stretch while the source keeps offering
		configure(3, 0, wnd_pkg::MODE_SIGNED, 12, 16);
		pace(0, 0);
		random_traffic(80);
		@(posedge clk);
		hold_req <= hold_req + 1;
		settle();

		for (k = 0; k < 4; k++) begin
			configure($urandom_range(7), $urandom_range(1), $urandom_range(3),
				$urandom_range(30, 1), $urandom_range(24, 1));
			case (k)
				0: pace(0, 0);
				1: pace(82, 0);
				2: pace(0, 82);
				default: pace(26, 26);
			endcase
			random_traffic(50);
			settle();
		end

		if (expected_diffs.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_diffs.size()));
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
